>>> sv/tts_pkg.sv
`timescale 1ns / 1ps
package tts_pkg;
	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0, OP_RELEASE = 3'd1, OP_BLOCK = 3'd2,
		OP_TICK = 3'd3, OP_VWAKE = 3'd4, OP_SCHED = 3'd5
	} op_t;
	typedef enum logic [1:0] {ST_UNUSED = 2'd0, ST_RUNNABLE = 2'd1, ST_BLOCKED = 2'd2} slot_st_t;
	localparam logic [2:0] WR_NONE  = 3'd0;
	localparam logic [2:0] WR_VFORK = 3'd1;
	localparam logic [2:0] WR_SLEEP = 3'd2;
	localparam logic [2:0] RS_OK = 3'd0;
	localparam logic [2:0] RS_FULL = 3'd1;
	localparam logic [2:0] RS_IGNORED = 3'd2;
	localparam logic [2:0] RS_WAIT = 3'd3;
	localparam logic [2:0] RS_NONE = 3'd4;

	typedef enum logic [2:0] {
		FS_IDLE, FS_PREP, FS_SCAN, FS_SCAN2, FS_FINISH, FS_OUT
	} fsm_t;

	typedef struct packed {
		logic load;      // latch input word, decide op
		logic prep;      // single-cycle part of op
		logic scan;      // examine slot at scan pointer
		logic finish;    // resolve scan result
		logic pass2;     // second schedule pass
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic need_scan;
		logic need_pass2;
	} stat_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  cpu;
		logic [3:0]  slot;
		logic [7:0]  domain;
		logic [1:0]  reason;
		logic [31:0] target;
		logic [63:0] deadline;
		logic [63:0] now;
		logic [31:0] wake_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  chosen_slot;
		logic [30:0] chosen_id;
		logic [4:0]  woken_count;
	} rsp_t;
endpackage

>>> sv/tts_if.sv
`timescale 1ns / 1ps
interface tts_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/tts_ctrl.sv
`timescale 1ns / 1ps
module tts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  tts_pkg::stat_t st,
	output tts_pkg::cmd_t  cmd
);
	import tts_pkg::*;
	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: if (in_valid) state_d = FS_PREP;
			FS_PREP: state_d = st.need_scan ? FS_SCAN : FS_OUT;
			FS_SCAN: begin
				if (st.found) state_d = FS_FINISH;
				else if (st.scan_last) state_d = st.need_pass2 ? FS_SCAN2 : FS_FINISH;
			end
			FS_SCAN2: state_d = FS_SCAN;
			FS_FINISH: state_d = FS_OUT;
			FS_OUT: if (out_ready) state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			FS_PREP: cmd.prep = 1'b1;
			FS_SCAN: cmd.scan = 1'b1;
			FS_SCAN2: cmd.pass2 = 1'b1;
			FS_FINISH: cmd.finish = 1'b1;
			FS_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

>>> sv/tts_dp.sv
`timescale 1ns / 1ps
module tts_dp #(
	parameter int THREAD_SLOTS = 16,
	parameter int CPU_COUNT = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tts_pkg::req_t  req,
	input  tts_pkg::cmd_t  cmd,
	output tts_pkg::stat_t st,
	output tts_pkg::rsp_t  rsp
);
	import tts_pkg::*;
	localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int PW = $clog2(THREAD_SLOTS + 1);

	slot_st_t          state_q [THREAD_SLOTS];
	logic              oncpu_q [THREAD_SLOTS];
	logic [CW-1:0]     cpu_q   [THREAD_SLOTS];
	logic [2:0]        wr_q    [THREAD_SLOTS];
	logic [31:0]       tgt_q   [THREAD_SLOTS];
	logic [63:0]       dl_q    [THREAD_SLOTS];
	logic [31:0]       tid_q   [THREAD_SLOTS];
	logic [7:0]        dom_q   [THREAD_SLOTS];
	logic [PW-1:0]     cur_q   [CPU_COUNT];
	logic [30:0]       next_id_q;

	req_t              r_q;
	logic [SW-1:0]     ptr_q;
	logic [PW-1:0]     cnt_q;
	logic              pass1_q;   // preferring own-cpu candidates
	logic              found_q;
	logic [SW-1:0]     cand_q;
	logic              blk_q, elsw_q;
	logic [4:0]        woken_q;
	rsp_t              rsp_q;
	logic              is_sched_q;

	logic              cpu_ok;
	logic [CW-1:0]     rcpu;
	logic [PW-1:0]     cur;
	logic              cur_ok;
	logic [SW-1:0]     cur_i;
	logic [SW-1:0]     start;
	logic              hit;
	logic              mine;
	logic [SW-1:0]     ptr_nx;

	assign cpu_ok = 32'(r_q.cpu) < CPU_COUNT;
	assign rcpu = CW'(r_q.cpu);
	assign cur = cur_q[rcpu];
	assign cur_ok = cur < PW'(THREAD_SLOTS);
	assign cur_i = SW'(cur);
	assign start = cur_ok ? ((32'(cur_i) == THREAD_SLOTS - 1) ? '0 : cur_i + 1'b1) : '0;
	assign ptr_nx = (32'(ptr_q) == THREAD_SLOTS - 1) ? '0 : ptr_q + 1'b1;
	assign mine = oncpu_q[ptr_q] && cpu_q[ptr_q] == rcpu;

	always_comb begin
		hit = 1'b0;
		unique case (r_q.op) inside
			OP_ALLOC: hit = state_q[ptr_q] == ST_UNUSED;
			OP_SCHED, OP_BLOCK: hit = state_q[ptr_q] == ST_RUNNABLE &&
				(!oncpu_q[ptr_q] || (pass1_q && mine));
			default: hit = 1'b0;
		endcase
	end

	assign st.found = is_sched_q ? hit : (r_q.op == OP_ALLOC && hit);
	assign st.scan_last = cnt_q == PW'(THREAD_SLOTS - 1);
	assign st.need_pass2 = is_sched_q && pass1_q;
	assign st.need_scan = (r_q.op == OP_ALLOC && r_q.domain != 8'd0)
		|| r_q.op == OP_TICK || r_q.op == OP_VWAKE
		|| (r_q.op == OP_SCHED && cpu_ok)
		|| (r_q.op == OP_BLOCK && cpu_ok && cur_ok && state_q[cur_i] == ST_RUNNABLE);
	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				state_q[i] <= ST_UNUSED; oncpu_q[i] <= 1'b0; cpu_q[i] <= '0;
				wr_q[i] <= WR_NONE; tgt_q[i] <= '0; dl_q[i] <= '0;
				tid_q[i] <= '0; dom_q[i] <= '0;
			end
			for (int c = 0; c < CPU_COUNT; c++) cur_q[c] <= PW'(THREAD_SLOTS);
			next_id_q <= 31'd1;
			ptr_q <= '0; cnt_q <= '0; pass1_q <= 1'b0; found_q <= 1'b0;
			cand_q <= '0; blk_q <= 1'b0; elsw_q <= 1'b0; woken_q <= '0;
			rsp_q <= '0; is_sched_q <= 1'b0;
		end else begin
			if (cmd.prep) begin
				cnt_q <= '0; found_q <= 1'b0; blk_q <= 1'b0; elsw_q <= 1'b0;
				woken_q <= '0;
				unique case (r_q.op)
					OP_RELEASE: begin
						is_sched_q <= 1'b0; ptr_q <= '0;
						if (32'(r_q.slot) < THREAD_SLOTS && dom_q[SW'(r_q.slot)] != 8'd0) begin
							state_q[SW'(r_q.slot)] <= ST_UNUSED;
							oncpu_q[SW'(r_q.slot)] <= 1'b0;
							dom_q[SW'(r_q.slot)] <= 8'd0;
							for (int c = 0; c < CPU_COUNT; c++)
								if (cur_q[c] == PW'(r_q.slot)) cur_q[c] <= PW'(THREAD_SLOTS);
							rsp_q <= '{RS_OK, r_q.slot, tid_q[SW'(r_q.slot)][30:0], 5'd0};
						end else rsp_q <= '{RS_IGNORED, 4'd0, 31'd0, 5'd0};
					end
					OP_BLOCK: begin
						rsp_q <= '{RS_IGNORED, 4'd0, 31'd0, 5'd0};
						if (cpu_ok && cur_ok && state_q[cur_i] == ST_RUNNABLE) begin
							oncpu_q[cur_i] <= 1'b0;
							state_q[cur_i] <= ST_BLOCKED;
							wr_q[cur_i] <= {1'b0, r_q.reason} + 3'd1;
							if (r_q.reason == 2'd1) dl_q[cur_i] <= r_q.deadline;
							else tgt_q[cur_i] <= r_q.target;
							// current thread is now blocked, so only the free-thread pass runs
							is_sched_q <= 1'b1;
							pass1_q <= 1'b0;
							ptr_q <= start;
						end else begin
							is_sched_q <= 1'b0; ptr_q <= '0;
						end
					end
					OP_SCHED: begin
						rsp_q <= '{RS_IGNORED, 4'd0, 31'd0, 5'd0};
						if (cpu_ok) begin
							is_sched_q <= 1'b1;
							pass1_q <= cur_ok && state_q[cur_i] == ST_RUNNABLE;
							ptr_q <= start;
						end else begin
							is_sched_q <= 1'b0; ptr_q <= '0;
						end
					end
					default: begin
						rsp_q <= '{RS_IGNORED, 4'd0, 31'd0, 5'd0};
						is_sched_q <= 1'b0; ptr_q <= '0;
					end
				endcase
			end
			if (cmd.scan) begin
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= ptr_nx;
				if (hit && !found_q) begin found_q <= 1'b1; cand_q <= ptr_q; end
				if (state_q[ptr_q] == ST_BLOCKED) blk_q <= 1'b1;
				if (state_q[ptr_q] == ST_RUNNABLE && oncpu_q[ptr_q] && !mine) elsw_q <= 1'b1;
				if (r_q.op == OP_TICK && state_q[ptr_q] == ST_BLOCKED &&
						wr_q[ptr_q] == WR_SLEEP && r_q.now >= dl_q[ptr_q]) begin
					state_q[ptr_q] <= ST_RUNNABLE; wr_q[ptr_q] <= WR_NONE;
					dl_q[ptr_q] <= '0; woken_q <= woken_q + 1'b1;
				end
				if (r_q.op == OP_VWAKE && state_q[ptr_q] == ST_BLOCKED &&
						wr_q[ptr_q] == WR_VFORK && tgt_q[ptr_q] == r_q.wake_id) begin
					state_q[ptr_q] <= ST_RUNNABLE; wr_q[ptr_q] <= WR_NONE;
					tgt_q[ptr_q] <= '1; woken_q <= woken_q + 1'b1;
				end
			end
			if (cmd.pass2) begin
				pass1_q <= 1'b0; cnt_q <= '0; ptr_q <= start;
				blk_q <= 1'b0; elsw_q <= 1'b0;
			end
			if (cmd.finish) begin
				unique case (r_q.op) inside
					OP_ALLOC: begin
						if (found_q) begin
							tid_q[cand_q] <= {1'b0, next_id_q};
							next_id_q <= (next_id_q == '1) ? 31'd1 : next_id_q + 1'b1;
							state_q[cand_q] <= ST_RUNNABLE; oncpu_q[cand_q] <= 1'b0;
							dom_q[cand_q] <= r_q.domain; wr_q[cand_q] <= WR_NONE;
							tgt_q[cand_q] <= '1; dl_q[cand_q] <= '0;
							rsp_q <= '{RS_OK, 4'(cand_q), next_id_q, 5'd0};
						end else rsp_q <= '{RS_FULL, 4'd0, 31'd0, 5'd0};
					end
					OP_TICK, OP_VWAKE: rsp_q <= '{RS_OK, 4'd0, 31'd0, woken_q};
					default: begin
						if (found_q) begin
							if (cur_ok && cur_i != cand_q && oncpu_q[cur_i] && cpu_q[cur_i] == rcpu)
								oncpu_q[cur_i] <= 1'b0;
							cur_q[rcpu] <= PW'(cand_q);
							oncpu_q[cand_q] <= 1'b1;
							cpu_q[cand_q] <= rcpu;
							rsp_q <= '{RS_OK, 4'(cand_q), tid_q[cand_q][30:0], 5'd0};
						end else
							rsp_q <= '{(blk_q || elsw_q) ? RS_WAIT : RS_NONE, 4'd0, 31'd0, 5'd0};
					end
				endcase
			end
		end
	end
endmodule

>>> sv/thread_table_scheduler_core.sv
`timescale 1ns / 1ps
// thread table scheduler: one request word in, one response word out
// in carries a tts_pkg::req_t (op, cpu, slot, domain, reason, target,
// deadline, now, wake_id); out carries a tts_pkg::rsp_t (status,
// chosen_slot, chosen_id, woken_count)
// one word is handled at a time: in_ready is high only when idle
// a request is taken in idle, handled in a prep step and, for ops that
// search the table, a scan, one slot examined a cycle, and a finish step:
// release, ignored and unknown ops: prep only, no scan
// allocate, tick, vfork wake, block: up to one pass over the THREAD_SLOTS
// slots; schedule while the current thread is runnable: up to
// two round-robin passes through the single scan pointer
// the controller returns to idle before the next request is taken
// the response holds in the output register while the receiver stalls;
// no new word is taken until it is taken
// reset clears the whole table at once: all slots unused, no cpu has a
// current thread, the id counter restarts at one
module thread_table_scheduler_core #(
	parameter int THREAD_SLOTS = 16,
	parameter int CPU_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	tts_if.sink   in,
	tts_if.source out
);
	import tts_pkg::*;
	cmd_t  cmd;
	stat_t st;
	rsp_t  rsp;

	tts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.st(st), .cmd(cmd)
	);

	tts_dp #(.THREAD_SLOTS(THREAD_SLOTS), .CPU_COUNT(CPU_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in.data), .cmd(cmd), .st(st), .rsp(rsp)
	);

	assign out.data = rsp;
endmodule
